// ----- rtl/core/evq_pkg.sv -----
package evq_pkg;

   localparam int RING_DEPTH    = 64;
   localparam int TYPE_COUNT    = 32;
   localparam int SUBS_PER_TYPE = 8;
   localparam int PAYLOAD_BYTES = 8;

   localparam int SLOT_W    = $clog2(RING_DEPTH);
   localparam int PTR_W     = SLOT_W + 1;
   localparam int TYPE_W    = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
   localparam int SUB_W     = (SUBS_PER_TYPE > 1) ? $clog2(SUBS_PER_TYPE) : 1;
   localparam int CNT_W     = $clog2(SUBS_PER_TYPE + 1);
   localparam int TBL_DEPTH = 1 << (TYPE_W + SUB_W);

   localparam logic [63:0] PAY_MASK = {64{1'b1}} >> (64 - 8 * PAYLOAD_BYTES);

   typedef enum logic [1:0] {
      CMD_PUBLISH     = 2'd0,
      CMD_DRAIN       = 2'd1,
      CMD_SUBSCRIBE   = 2'd2,
      CMD_UNSUBSCRIBE = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STAT_OK        = 3'd0,
      STAT_INVALID   = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_NOT_FOUND = 3'd3,
      STAT_EMPTY     = 3'd4,
      STAT_NO_SUB    = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_RING_WAIT,
      S_DRAIN_RD,
      S_DRAIN_EMIT,
      S_UNSUB_RD,
      S_UNSUB_CMP,
      S_UNSUB_MOVE,
      S_EMIT
   } state_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [7:0]  event_type;
      logic [31:0] source_entity;
      logic [31:0] target_entity;
      logic [63:0] time_ns;
      logic [63:0] payload_word;
      logic [15:0] subscriber_id;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] out_subscriber;
      logic [7:0]  out_type;
      logic [31:0] out_source;
      logic [31:0] out_target;
      logic [63:0] out_time;
      logic [63:0] out_payload;
      logic        last;
      logic [6:0]  pending_count;
      logic [63:0] published_total;
      logic [63:0] dropped_total;
      logic [63:0] dispatched_total;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  kind;
      logic [31:0] from;
      logic [31:0] to;
      logic [63:0] stamp;
      logic [63:0] data;
   } event_type_t_type;

endpackage

// ----- rtl/core/evq_front.sv -----
module evq_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  evq_pkg::req_type push_item,
   input  logic             pop,
   output logic             empty,
   output evq_pkg::req_type pop_item
);
   import evq_pkg::*;

   req_type    mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? ~wr_ff : wr_ff;
      rd_in  = do_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/core/evq_rsp_queue.sv -----
module evq_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  evq_pkg::rsp_type push_item,
   input  logic             pop,
   output logic             empty,
   output evq_pkg::rsp_type pop_item
);
   import evq_pkg::*;

   rsp_type    mem_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? ~wr_ff : wr_ff;
      rd_in  = do_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/core/evq_back.sv -----
module evq_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_empty,
   output logic             cmd_pop,
   input  evq_pkg::req_type cmd_item,
   input  logic             rsp_full,
   output logic             rsp_push,
   output evq_pkg::rsp_type rsp_item
);
   import evq_pkg::*;

   state_type            state_ff, state_in;
   req_type              cmd_ff, cmd_in;
   logic [PTR_W-1:0]     rp_ff, rp_in;
   logic [PTR_W-1:0]     wp_ff, wp_in;
   logic [63:0]          acc_ff, acc_in;
   logic [63:0]          drop_ff, drop_in;
   logic [63:0]          drain_ff, drain_in;
   logic [CNT_W-1:0]     count_ff [TYPE_COUNT];
   status_type           status_ff, status_in;
   logic                 has_event_ff, has_event_in;
   logic [SUB_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   // Ring storage, one entry per pending event.
   event_type_t_type     ring_mem [RING_DEPTH];
   event_type_t_type     ring_rd_ff;
   logic                 ring_we, ring_re;
   event_type_t_type     ring_wdata;

   // Subscriber table, addressed by type and list position.
   logic [15:0]          tbl_mem [TBL_DEPTH];
   logic [15:0]          tbl_rd_ff;
   logic                 tbl_we, tbl_re;
   logic [TYPE_W+SUB_W-1:0] tbl_waddr, tbl_raddr;
   logic [15:0]          tbl_wdata;

   logic                 count_we;
   logic [CNT_W-1:0]     count_wdata;
   logic [TYPE_W-1:0]    cur_type;
   logic [CNT_W-1:0]     cur_count;
   logic [TYPE_W-1:0]    cmd_tidx, kind_tidx;
   logic                 cmd_type_ok, kind_ok;
   logic [PTR_W-1:0]     pending;
   logic                 ring_full, ring_empty;
   logic                 idx_last;

   assign pending     = wp_ff - rp_ff;
   assign ring_full   = (pending == PTR_W'(RING_DEPTH));
   assign ring_empty  = (pending == '0);
   assign cmd_tidx    = cmd_ff.event_type[TYPE_W-1:0];
   assign kind_tidx   = ring_rd_ff.kind[TYPE_W-1:0];
   assign cmd_type_ok = (9'(cmd_ff.event_type) < 9'(TYPE_COUNT));
   assign kind_ok     = (9'(ring_rd_ff.kind) < 9'(TYPE_COUNT));
   assign cur_type    = (state_ff == S_RING_WAIT) ? kind_tidx : cmd_tidx;
   assign cur_count   = count_ff[cur_type];
   assign idx_last    = ((CNT_W + 1)'(idx_ff) + 1'b1) == (CNT_W + 1)'(cnt_ff);

   always_comb begin
      ring_wdata.kind  = cmd_ff.event_type;
      ring_wdata.from  = cmd_ff.source_entity;
      ring_wdata.to    = cmd_ff.target_entity;
      ring_wdata.stamp = cmd_ff.time_ns;
      ring_wdata.data  = cmd_ff.payload_word & PAY_MASK;
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      acc_in       = acc_ff;
      drop_in      = drop_ff;
      drain_in     = drain_ff;
      status_in    = status_ff;
      has_event_in = has_event_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      cmd_pop      = 1'b0;
      rsp_push     = 1'b0;
      ring_we      = 1'b0;
      ring_re      = 1'b0;
      tbl_we       = 1'b0;
      tbl_re       = 1'b0;
      tbl_waddr    = {cmd_tidx, idx_ff};
      tbl_raddr    = {cmd_tidx, idx_ff};
      tbl_wdata    = cmd_ff.subscriber_id;
      count_we     = 1'b0;
      count_wdata  = cur_count;
      case (state_ff)
         S_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd_item;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            has_event_in = 1'b0;
            state_in     = S_EMIT;
            case (cmd_ff.cmd)
               CMD_PUBLISH: begin
                  if (ring_full) begin
                     drop_in   = drop_ff + 64'd1;
                     status_in = STAT_FULL;
                  end else begin
                     ring_we   = 1'b1;
                     wp_in     = wp_ff + 1'b1;
                     acc_in    = acc_ff + 64'd1;
                     status_in = STAT_OK;
                  end
               end
               CMD_DRAIN: begin
                  if (ring_empty) begin
                     status_in = STAT_EMPTY;
                  end else begin
                     ring_re  = 1'b1;
                     rp_in    = rp_ff + 1'b1;
                     drain_in = drain_ff + 64'd1;
                     state_in = S_RING_WAIT;
                  end
               end
               CMD_SUBSCRIBE: begin
                  if (cmd_ff.subscriber_id == 16'd0 || !cmd_type_ok) begin
                     status_in = STAT_INVALID;
                  end else if (32'(cur_count) >= 32'(SUBS_PER_TYPE)) begin
                     status_in = STAT_FULL;
                  end else begin
                     tbl_we      = 1'b1;
                     tbl_waddr   = {cmd_tidx, cur_count[SUB_W-1:0]};
                     count_we    = 1'b1;
                     count_wdata = cur_count + 1'b1;
                     status_in   = STAT_OK;
                  end
               end
               default: begin
                  if (cmd_ff.subscriber_id == 16'd0 || !cmd_type_ok) begin
                     status_in = STAT_INVALID;
                  end else if (cur_count == '0) begin
                     status_in = STAT_NOT_FOUND;
                  end else begin
                     cnt_in   = cur_count;
                     idx_in   = '0;
                     state_in = S_UNSUB_RD;
                  end
               end
            endcase
         end
         S_RING_WAIT: begin
            if (!kind_ok || cur_count == '0) begin
               status_in    = STAT_NO_SUB;
               has_event_in = 1'b1;
               state_in     = S_EMIT;
            end else begin
               cnt_in   = cur_count;
               idx_in   = '0;
               state_in = S_DRAIN_RD;
            end
         end
         S_DRAIN_RD: begin
            tbl_re    = 1'b1;
            tbl_raddr = {kind_tidx, idx_ff};
            state_in  = S_DRAIN_EMIT;
         end
         S_DRAIN_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (idx_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_DRAIN_RD;
               end
            end
         end
         S_UNSUB_RD: begin
            tbl_re   = 1'b1;
            state_in = S_UNSUB_CMP;
         end
         S_UNSUB_CMP: begin
            if (tbl_rd_ff == cmd_ff.subscriber_id) begin
               // Fetch the list's last handle to move into the hole.
               tbl_re    = 1'b1;
               tbl_raddr = {cmd_tidx, SUB_W'(cnt_ff - 1'b1)};
               state_in  = S_UNSUB_MOVE;
            end else if (idx_last) begin
               status_in = STAT_NOT_FOUND;
               state_in  = S_EMIT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_UNSUB_RD;
            end
         end
         S_UNSUB_MOVE: begin
            tbl_we      = 1'b1;
            tbl_wdata   = tbl_rd_ff;
            count_we    = 1'b1;
            count_wdata = cnt_ff - 1'b1;
            status_in   = STAT_OK;
            state_in    = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      logic drain_out;
      logic show_event;
      drain_out  = (state_ff == S_DRAIN_EMIT);
      show_event = drain_out || has_event_ff;
      rsp_item.status           = drain_out ? STAT_OK : status_ff;
      rsp_item.out_subscriber   = drain_out ? tbl_rd_ff : 16'd0;
      rsp_item.out_type         = show_event ? ring_rd_ff.kind : 8'd0;
      rsp_item.out_source       = show_event ? ring_rd_ff.from : 32'd0;
      rsp_item.out_target       = show_event ? ring_rd_ff.to : 32'd0;
      rsp_item.out_time         = show_event ? ring_rd_ff.stamp : 64'd0;
      rsp_item.out_payload      = show_event ? ring_rd_ff.data : 64'd0;
      rsp_item.last             = drain_out ? idx_last : 1'b1;
      rsp_item.pending_count    = 7'(pending);
      rsp_item.published_total  = acc_ff;
      rsp_item.dropped_total    = drop_ff;
      rsp_item.dispatched_total = drain_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rp_ff    <= '0;
         wp_ff    <= '0;
         acc_ff   <= 64'd0;
         drop_ff  <= 64'd0;
         drain_ff <= 64'd0;
         for (int i = 0; i < TYPE_COUNT; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rp_ff    <= rp_in;
         wp_ff    <= wp_in;
         acc_ff   <= acc_in;
         drop_ff  <= drop_in;
         drain_ff <= drain_in;
         if (count_we) begin
            count_ff[cur_type] <= count_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      status_ff    <= status_in;
      has_event_ff <= has_event_in;
      idx_ff       <= idx_in;
      cnt_ff       <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[wp_ff[SLOT_W-1:0]] <= ring_wdata;
      end
      if (ring_re) begin
         ring_rd_ff <= ring_mem[rp_ff[SLOT_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      if (tbl_re) begin
         tbl_rd_ff <= tbl_mem[tbl_raddr];
      end
   end

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      32'(pending) <= 32'(RING_DEPTH))
      else $error("ring holds more events than its depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into a full queue");

   a_ring_write_room: assert property (@(posedge clock) disable iff (reset)
      ring_we |-> !ring_full)
      else $error("event stored into a full ring");

   a_drain_moves_rp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RING_WAIT) |-> (rp_ff == $past(rp_ff) + 1'b1))
      else $error("drain did not advance the read pointer");

endmodule

// ----- rtl/core/event_queue_subscriber_fanout.sv -----
// Channel   Ports                          Moves
// req       req_push, req_full, req_item   one command item
// rsp       rsp_empty, rsp_pop, rsp_item   one result item
//
// Publish and subscribe pass the back sequencer through take, execute and emit;
// the result is pushed into the result queue from the emit state.
// Drain adds a ring read wait, then a table read and an emit state per subscriber,
// set by the single read port of the subscriber table, or gives a single status result.
// Unsubscribe adds a read and a compare state per entry scanned, and a move on a match.
// Reset is synchronous and clears pointers, counters and list counts.
// A full result queue stalls the sequencer; the command queue keeps accepting
// items until its two entries are taken.
module event_queue_subscriber_fanout (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  evq_pkg::req_type req_item,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output evq_pkg::rsp_type rsp_item
);
   import evq_pkg::*;

   logic    cmd_empty, cmd_pop;
   req_type cmd_item;
   logic    rq_full, rq_push;
   rsp_type rq_item;

   evq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .push_item (req_item),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .pop_item  (cmd_item)
   );

   evq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_item  (cmd_item),
      .rsp_full  (rq_full),
      .rsp_push  (rq_push),
      .rsp_item  (rq_item)
   );

   evq_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rq_push),
      .full      (rq_full),
      .push_item (rq_item),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_item  (rsp_item)
   );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import evq_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_item = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_item;

   event_queue_subscriber_fanout dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_item(req_item),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_item(rsp_item)
   );

   always #5 clock = ~clock;

   // Shadow copy of the event bus state.
   logic [7:0]  ev_kind  [RING_DEPTH];
   logic [31:0] ev_from  [RING_DEPTH];
   logic [31:0] ev_to    [RING_DEPTH];
   logic [63:0] ev_stamp [RING_DEPTH];
   logic [63:0] ev_data  [RING_DEPTH];
   logic [PTR_W-1:0] rd_ptr, wr_ptr;
   logic [15:0] handles [TYPE_COUNT][SUBS_PER_TYPE];
   int          handle_cnt [TYPE_COUNT];
   logic [63:0] n_published, n_dropped, n_dispatched;

   rsp_type expected_rsps[$];
   int      error_count = 0;
   int      rsp_count = 0;
   int      item_count = 0;
   bit      idle_on = 1'b1;
   bit      hold_rsp = 1'b0;

   function automatic int pending();
      return int'(PTR_W'(wr_ptr - rd_ptr));
   endfunction

   function automatic rsp_type make_rsp(status_type st, logic [15:0] sub,
                                        int slot, bit with_event, bit is_last);
      rsp_type r;
      r = '0;
      r.status = st;
      r.out_subscriber = sub;
      if (with_event) begin
         r.out_type = ev_kind[slot];
         r.out_source = ev_from[slot];
         r.out_target = ev_to[slot];
         r.out_time = ev_stamp[slot];
         r.out_payload = ev_data[slot];
      end
      r.last = is_last;
      r.pending_count = 7'(pending());
      r.published_total = n_published;
      r.dropped_total = n_dropped;
      r.dispatched_total = n_dispatched;
      return r;
   endfunction

   task automatic predict_bus(input req_type c);
      int slot, cnt, t;
      bit hit;
      t = c.event_type;
      case (c.cmd)
         CMD_PUBLISH: begin
            if (pending() >= RING_DEPTH) begin
               n_dropped++;
               expected_rsps.push_back(make_rsp(STAT_FULL, 0, 0, 0, 1));
            end else begin
               slot = wr_ptr[SLOT_W-1:0];
               ev_kind[slot] = c.event_type;
               ev_from[slot] = c.source_entity;
               ev_to[slot] = c.target_entity;
               ev_stamp[slot] = c.time_ns;
               ev_data[slot] = c.payload_word & PAY_MASK;
               wr_ptr++;
               n_published++;
               expected_rsps.push_back(make_rsp(STAT_OK, 0, 0, 0, 1));
            end
         end
         CMD_DRAIN: begin
            if (pending() == 0) begin
               expected_rsps.push_back(make_rsp(STAT_EMPTY, 0, 0, 0, 1));
            end else begin
               slot = rd_ptr[SLOT_W-1:0];
               rd_ptr++;
               n_dispatched++;
               t = ev_kind[slot];
               cnt = (t < TYPE_COUNT) ? handle_cnt[t] : 0;
               if (cnt == 0)
                  expected_rsps.push_back(make_rsp(STAT_NO_SUB, 0, slot, 1, 1));
               for (int i = 0; i < cnt; i++)
                  expected_rsps.push_back(make_rsp(STAT_OK, handles[t][i], slot, 1,
                                                   i + 1 == cnt));
            end
         end
         default: begin
            if (c.subscriber_id == 0 || t >= TYPE_COUNT) begin
               expected_rsps.push_back(make_rsp(STAT_INVALID, 0, 0, 0, 1));
            end else if (c.cmd == CMD_SUBSCRIBE) begin
               if (handle_cnt[t] >= SUBS_PER_TYPE) begin
                  expected_rsps.push_back(make_rsp(STAT_FULL, 0, 0, 0, 1));
               end else begin
                  handles[t][handle_cnt[t]] = c.subscriber_id;
                  handle_cnt[t]++;
                  expected_rsps.push_back(make_rsp(STAT_OK, 0, 0, 0, 1));
               end
            end else begin
               hit = 1'b0;
               cnt = handle_cnt[t];
               for (int i = 0; i < cnt && !hit; i++) begin
                  if (handles[t][i] == c.subscriber_id) begin
                     handles[t][i] = handles[t][cnt - 1];
                     handle_cnt[t] = cnt - 1;
                     hit = 1'b1;
                  end
               end
               expected_rsps.push_back(make_rsp(hit ? STAT_OK : STAT_NOT_FOUND,
                                                0, 0, 0, 1));
            end
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("mismatch on result %0d: %s got %h expected %h", rsp_count, what,
               got, want);
   endtask

   // The item stays on the ports after acceptance until the next item or an idle.
   task automatic send_item(input req_type c);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= c;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_bus(c);
      item_count++;
   endtask

   function automatic req_type rand_item(cmd_type op);
      req_type c;
      c.cmd = op;
      c.event_type = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
      c.source_entity = $urandom;
      c.target_entity = $urandom;
      c.time_ns = {$urandom, $urandom};
      c.payload_word = {$urandom, $urandom};
      c.subscriber_id = ($urandom_range(0, 15) == 0) ? 16'd0 :
                        ($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(1, 6)));
      return c;
   endfunction

   function automatic req_type cmd_item(cmd_type op, logic [7:0] t, logic [15:0] h);
      req_type c;
      c = rand_item(op);
      c.event_type = t;
      c.subscriber_id = h;
      return c;
   endfunction

   // Result checker and receiver stalls.
   initial begin
      rsp_type want;
      int gap;
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected result", 0, 0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_item.status !== want.status)
                  report_mismatch("status", rsp_item.status, want.status);
               if (rsp_item.out_subscriber !== want.out_subscriber)
                  report_mismatch("out_subscriber", rsp_item.out_subscriber,
                                  want.out_subscriber);
               if (rsp_item.out_type !== want.out_type)
                  report_mismatch("out_type", rsp_item.out_type, want.out_type);
               if (rsp_item.out_source !== want.out_source)
                  report_mismatch("out_source", rsp_item.out_source, want.out_source);
               if (rsp_item.out_target !== want.out_target)
                  report_mismatch("out_target", rsp_item.out_target, want.out_target);
               if (rsp_item.out_time !== want.out_time)
                  report_mismatch("out_time", rsp_item.out_time, want.out_time);
               if (rsp_item.out_payload !== want.out_payload)
                  report_mismatch("out_payload", rsp_item.out_payload,
                                  want.out_payload);
               if (rsp_item.last !== want.last)
                  report_mismatch("last", rsp_item.last, want.last);
               if (rsp_item.pending_count !== want.pending_count)
                  report_mismatch("pending_count", rsp_item.pending_count,
                                  want.pending_count);
               if (rsp_item.published_total !== want.published_total)
                  report_mismatch("published_total", rsp_item.published_total,
                                  want.published_total);
               if (rsp_item.dropped_total !== want.dropped_total)
                  report_mismatch("dropped_total", rsp_item.dropped_total,
                                  want.dropped_total);
               if (rsp_item.dispatched_total !== want.dispatched_total)
                  report_mismatch("dispatched_total", rsp_item.dispatched_total,
                                  want.dispatched_total);
            end
            rsp_count++;
         end
         if (reset || hold_rsp) begin
            rsp_pop <= 1'b0;
         end else if (idle_on && rsp_pop && $urandom_range(0, 5) == 0) begin
            // Nothing is accepted while pop is low, so these edges need no check.
            rsp_pop <= 1'b0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(posedge clock);
            rsp_pop <= 1'b1;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   task automatic wait_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      req_type c;
      send_item(cmd_item(CMD_DRAIN, 8'd0, 16'd1));
      send_item(cmd_item(CMD_SUBSCRIBE, 8'd0, 16'd0));
      send_item(cmd_item(CMD_SUBSCRIBE, 8'(TYPE_COUNT), 16'd5));
      send_item(cmd_item(CMD_SUBSCRIBE, 8'hff, 16'hffff));
      send_item(cmd_item(CMD_UNSUBSCRIBE, 8'd3, 16'd9));
      for (int i = 0; i < SUBS_PER_TYPE; i++)
         send_item(cmd_item(CMD_SUBSCRIBE, 8'(TYPE_COUNT - 1),
                            (i == 1) ? 16'hffff : 16'd7));
      send_item(cmd_item(CMD_SUBSCRIBE, 8'(TYPE_COUNT - 1), 16'd3));
      c = cmd_item(CMD_PUBLISH, 8'(TYPE_COUNT - 1), 16'd0);
      c.source_entity = '1; c.target_entity = '0;
      c.time_ns = '1; c.payload_word = '1;
      send_item(c);
      c = cmd_item(CMD_PUBLISH, 8'hff, 16'd0);
      c.source_entity = '0; c.target_entity = '1; c.time_ns = '0; c.payload_word = '0;
      send_item(c);
      send_item(cmd_item(CMD_PUBLISH, 8'd4, 16'd0));
      send_item(cmd_item(CMD_DRAIN, 8'd0, 16'd0));
      send_item(cmd_item(CMD_DRAIN, 8'd0, 16'd0));
      send_item(cmd_item(CMD_DRAIN, 8'd0, 16'd0));
      send_item(cmd_item(CMD_UNSUBSCRIBE, 8'(TYPE_COUNT - 1), 16'd7));
      send_item(cmd_item(CMD_UNSUBSCRIBE, 8'(TYPE_COUNT - 1), 16'hffff));
      send_item(cmd_item(CMD_UNSUBSCRIBE, 8'(TYPE_COUNT - 1), 16'hffff));
      wait_drained();
   endtask

   // Fill the ring past its depth with the receiver held off, then empty it.
   task automatic test_ring_full();
      hold_rsp = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < RING_DEPTH + 3; i++) send_item(rand_item(CMD_PUBLISH));
      join
      for (int i = 0; i < RING_DEPTH + 1; i++) send_item(rand_item(CMD_DRAIN));
      wait_drained();
   endtask

   task automatic test_random(input int n);
      int r;
      cmd_type op;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         op = (r < 40) ? CMD_PUBLISH : (r < 70) ? CMD_DRAIN :
              (r < 88) ? CMD_SUBSCRIBE : CMD_UNSUBSCRIBE;
         send_item(rand_item(op));
         if (i == n / 2) wait_drained();
      end
   endtask

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

   initial begin
      rd_ptr = '0; wr_ptr = '0;
      n_published = '0; n_dropped = '0; n_dispatched = '0;
      foreach (handle_cnt[i]) handle_cnt[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_ring_full();
      test_random(120);
      idle_on = 1'b0;
      test_random(40);
      wait_drained();
      repeat (50) @(posedge clock);
      $display("covered %0d items and %0d results: publish, drain with fan-out,",
               item_count, rsp_count);
      $display("subscribe, unsubscribe, full ring with drops and stalls");
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
